/* rtl/a2q_pkg.sv */
package a2q_pkg;

   // Configuration register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_AXIS_MASK      = 2'd0,
      REG_THRESHOLD_HIGH = 2'd1,
      REG_THRESHOLD_LOW  = 2'd2,
      REG_IDLE_FRAMES    = 2'd3
   } reg_index_type;

   // Field widths fixed by the stream format
   localparam int AXIS_WIDTH      = 3;
   localparam int SAMPLE_WIDTH    = 12;
   localparam int THRESHOLD_WIDTH = 11;
   localparam int IDLE_WIDTH      = 16;
   localparam int MASK_WIDTH      = 8;

   // Default parameter values
   localparam int AXIS_COUNT_DEFAULT = 8;
   localparam int ANGLE_BITS_DEFAULT = 12;

   // Register reset values
   localparam logic [MASK_WIDTH-1:0]      MASK_RESET     = 8'd0;
   localparam logic [THRESHOLD_WIDTH-1:0] THR_HIGH_RESET = 11'd1000;
   localparam logic [THRESHOLD_WIDTH-1:0] THR_LOW_RESET  = 11'd200;
   localparam logic [IDLE_WIDTH-1:0]      IDLE_RESET     = 16'd200;
   localparam logic [IDLE_WIDTH-1:0]      IDLE_MAX       = 16'hFFFF;

   // Quadrature outputs per phase, bit n is phase n
   localparam logic [3:0] QUAD_A = 4'b0011;
   localparam logic [3:0] QUAD_B = 4'b0110;

   // One result item
   typedef struct packed {
      logic                  phase_b;
      logic                  phase_a;
      logic [AXIS_WIDTH-1:0] axis_slot;
   } rsp_type;

endpackage

/* rtl/angle_to_quadrature_encoder.sv */
// Angle samples in, emulated quadrature A/B per axis out.
// A result is on rsp_tvalid in the cycle after its request is accepted
// when the output register is free; it waits longer while rsp_tready is low.
// Throughput: one request per cycle; state updates in the accept cycle. While rsp
// stalls, one skid entry takes one more request, then req_tready drops.
// Reset (synchronous, active high): anchors and phases zero (all axes
// unprimed), threshold 1000, idle counter zero, registers to their defaults.
module angle_to_quadrature_encoder #(
   parameter int AXIS_COUNT = a2q_pkg::AXIS_COUNT_DEFAULT,
   parameter int ANGLE_BITS = a2q_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [2:0] axis_number, [14:3] angle_sample, [15] zero
   input  logic        req_tuser,   // [0] frame_start
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] axis_slot, [3] phase_a, [4] phase_b, [7:5] zero
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int DW = (ANGLE_BITS + 2 > 13) ? ANGLE_BITS + 2 : 13;
   localparam logic signed [DW-1:0] ANGLE_FULL = DW'(2 ** ANGLE_BITS);
   localparam logic signed [DW-1:0] ANGLE_HALF = DW'(2 ** (ANGLE_BITS - 1));

   localparam int TW = a2q_pkg::THRESHOLD_WIDTH;
   localparam int IW = a2q_pkg::IDLE_WIDTH;

   // configuration registers
   logic [a2q_pkg::MASK_WIDTH-1:0] mask_ff;
   logic [TW-1:0]                  thr_high_ff;
   logic [TW-1:0]                  thr_low_ff;
   logic [IW-1:0]                  idle_frames_ff;

   // block state
   logic [ANGLE_BITS-1:0] anchor_ff [AXIS_COUNT];
   logic [1:0]            phase_ff  [AXIS_COUNT];
   logic [TW-1:0]         thr_ff, thr_in;
   logic [IW-1:0]         idle_ff, idle_in;

   // request fields
   logic [a2q_pkg::AXIS_WIDTH-1:0]   req_axis;
   logic [a2q_pkg::SAMPLE_WIDTH-1:0] req_angle;
   logic                             req_frame;
   logic [AW-1:0]                    axis_idx;
   logic [ANGLE_BITS-1:0]            curr;

   logic                  req_accept;
   logic                  axis_hit;
   logic                  push;
   logic                  push_ready;
   logic                  primed;
   logic [ANGLE_BITS-1:0] anchor_cur;
   logic [1:0]            phase_cur;
   logic [1:0]            phase_new;
   logic signed [DW-1:0]  delta_raw;
   logic signed [DW-1:0]  delta;
   logic signed [DW-1:0]  thr_s;
   logic                  step_up;
   logic                  step_down;
   logic                  step;
   logic [IW-1:0]         idle_inc;
   a2q_pkg::rsp_type      push_data;
   a2q_pkg::rsp_type      rsp_data;
   a2q_pkg::reg_index_type csr_index;
   logic                  csr_write;

   assign req_axis  = req_tdata[2:0];
   assign req_angle = req_tdata[14:3];
   assign req_frame = req_tuser;
   assign axis_idx  = req_axis[AW-1:0];
   assign curr      = ANGLE_BITS'(req_angle);

   assign req_accept = req_tvalid & req_tready;
   assign req_tready = push_ready;
   assign axis_hit   = (int'(req_axis) < AXIS_COUNT) && mask_ff[req_axis];
   assign push       = req_accept & axis_hit;

   assign anchor_cur = anchor_ff[axis_idx];
   assign phase_cur  = phase_ff[axis_idx];
   assign primed     = (anchor_cur != '0);

   // shortest signed delta around the circle; a half turn keeps its sign
   always_comb begin
      delta_raw = $signed(DW'(curr)) - $signed(DW'(anchor_cur));
      if (delta_raw > ANGLE_HALF) begin
         delta = delta_raw - ANGLE_FULL;
      end else if (delta_raw < -ANGLE_HALF) begin
         delta = delta_raw + ANGLE_FULL;
      end else begin
         delta = delta_raw;
      end
   end

   assign thr_s     = $signed(DW'(thr_ff));
   assign step_up   = primed && (delta > thr_s);
   assign step_down = primed && !step_up && (delta < -thr_s);
   assign step      = step_up | step_down;

   always_comb begin
      if (step_up) begin
         phase_new = phase_cur + 2'd1;
      end else if (step_down) begin
         phase_new = phase_cur - 2'd1;
      end else begin
         phase_new = phase_cur;
      end
   end

   // frame start advances the saturating idle counter first
   assign idle_inc = (req_frame && idle_ff != a2q_pkg::IDLE_MAX) ? idle_ff + 1'b1 : idle_ff;

   always_comb begin
      idle_in = idle_ff;
      thr_in  = thr_ff;
      if (req_accept) begin
         idle_in = idle_inc;
         if (push && step) begin
            idle_in = '0;
            thr_in  = thr_low_ff;
         end else if (push && primed && idle_inc > idle_frames_ff
                      && thr_ff < thr_high_ff) begin
            thr_in = thr_ff + 1'b1;
         end
      end
   end

   // result: zeros while unprimed
   always_comb begin
      push_data.axis_slot = req_axis;
      push_data.phase_a   = primed ? a2q_pkg::QUAD_A[phase_new] : 1'b0;
      push_data.phase_b   = primed ? a2q_pkg::QUAD_B[phase_new] : 1'b0;
   end

   // shared state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= a2q_pkg::THR_HIGH_RESET;
         idle_ff <= '0;
      end else begin
         thr_ff  <= thr_in;
         idle_ff <= idle_in;
      end
   end

   // per-axis anchor and phase
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < AXIS_COUNT; n++) begin
            anchor_ff[n] <= '0;
            phase_ff[n]  <= '0;
         end
      end else if (push) begin
         if (!primed || step) begin
            anchor_ff[axis_idx] <= curr;
         end
         phase_ff[axis_idx] <= phase_new;
      end
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = a2q_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff        <= a2q_pkg::MASK_RESET;
         thr_high_ff    <= a2q_pkg::THR_HIGH_RESET;
         thr_low_ff     <= a2q_pkg::THR_LOW_RESET;
         idle_frames_ff <= a2q_pkg::IDLE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            a2q_pkg::REG_AXIS_MASK:      mask_ff        <= csr_pwdata[a2q_pkg::MASK_WIDTH-1:0];
            a2q_pkg::REG_THRESHOLD_HIGH: thr_high_ff    <= csr_pwdata[TW-1:0];
            a2q_pkg::REG_THRESHOLD_LOW:  thr_low_ff     <= csr_pwdata[TW-1:0];
            a2q_pkg::REG_IDLE_FRAMES:    idle_frames_ff <= csr_pwdata[IW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         a2q_pkg::REG_AXIS_MASK:      csr_prdata = 32'(mask_ff);
         a2q_pkg::REG_THRESHOLD_HIGH: csr_prdata = 32'(thr_high_ff);
         a2q_pkg::REG_THRESHOLD_LOW:  csr_prdata = 32'(thr_low_ff);
         a2q_pkg::REG_IDLE_FRAMES:    csr_prdata = 32'(idle_frames_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // result buffer
   a2q_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {3'b000, rsp_data.phase_b, rsp_data.phase_a, rsp_data.axis_slot};

   // an accepted enabled request always leaves rsp_tvalid high next cycle
   a_push_result: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_tvalid)
      else $error("accepted request produced no result");

   // a phase step clears the idle counter and loads the low threshold
   a_step_clears_idle: assert property (@(posedge clock) disable iff (reset)
      (push && step) |=> (idle_ff == '0 && thr_ff == $past(thr_low_ff)))
      else $error("step did not reset idle state");

   // the threshold moves by at most one unless a step loaded it
   a_thr_creep: assert property (@(posedge clock) disable iff (reset)
      !(push && step) |=> (thr_ff == $past(thr_ff) || thr_ff == $past(thr_ff) + 1'b1))
      else $error("threshold jumped without a step");

   // requests are refused only while a result is pending
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request blocked with no pending result");

endmodule

/* rtl/a2q_rsp_buf.sv */
module a2q_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  a2q_pkg::rsp_type push_data,
   output logic             push_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output a2q_pkg::rsp_type rsp_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   a2q_pkg::rsp_type out_data_ff, out_data_in;
   a2q_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             pop;

   assign pop        = out_valid_ff & rsp_ready;
   assign push_ready = ~skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   // output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // skid entry only fills behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a stalled result with a full skid entry keeps both
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> (skid_valid_ff && out_valid_ff))
      else $error("buffered result lost");

   // a push into a busy output stage lands in the skid entry
   a_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && !skid_valid_ff && out_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("request result dropped");

endmodule

/* bench/angle_to_quadrature_encoder_test.sv */
module angle_to_quadrature_encoder_test;

   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 4;
   localparam int ANGLE_RANGE  = 1 << a2q_pkg::SAMPLE_WIDTH;
   localparam int ANGLE_HALF   = ANGLE_RANGE / 2;
   localparam int AXES         = a2q_pkg::AXIS_COUNT_DEFAULT;
   localparam int AXW          = a2q_pkg::AXIS_WIDTH;
   localparam int SW           = a2q_pkg::SAMPLE_WIDTH;
   localparam int MW           = a2q_pkg::MASK_WIDTH;
   localparam int TW           = a2q_pkg::THRESHOLD_WIDTH;
   localparam int IW           = a2q_pkg::IDLE_WIDTH;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [2:0] axis_number, [14:3] angle_sample, [15] zero
   logic        req_tuser = 1'b0; // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [2:0] axis_slot, [3] phase_a, [4] phase_b, [7:5] zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   angle_to_quadrature_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Encoder emulation state, mirrored from the register writes
   logic [MW-1:0] axis_enable   = a2q_pkg::MASK_RESET;
   logic [TW-1:0] thr_high      = a2q_pkg::THR_HIGH_RESET;
   logic [TW-1:0] thr_low       = a2q_pkg::THR_LOW_RESET;
   logic [TW-1:0] threshold_now = a2q_pkg::THR_HIGH_RESET;
   logic [IW-1:0] idle_limit    = a2q_pkg::IDLE_RESET;
   logic [IW-1:0] idle_count    = '0;
   logic [SW-1:0] anchor [AXES];
   logic [1:0]    phase  [AXES];

   a2q_pkg::rsp_type pending_quadrature [$];

   int error_count   = 0;
   int send_idle_pct = 8;
   int recv_idle_pct = 77;
   int quiet_cycles  = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Expected encoder outputs for one accepted request
   function automatic void emulate_encoder(input logic [AXW-1:0] axis,
                                           input logic [SW-1:0] sample,
                                           input logic frame);
      int               delta;
      logic             stepped;
      a2q_pkg::rsp_type quad;
      stepped = 1'b0;
      if (frame && idle_count != a2q_pkg::IDLE_MAX)
         idle_count = idle_count + 1'b1;
      if (!axis_enable[axis])
         return;
      quad.axis_slot = axis;
      // unprimed axis: outputs low, sample becomes the anchor
      if (anchor[axis] == '0) begin
         anchor[axis] = sample;
         quad.phase_a = 1'b0;
         quad.phase_b = 1'b0;
         pending_quadrature.push_back(quad);
         return;
      end
      // shortest signed distance around the circle
      delta = int'(sample) - int'(anchor[axis]);
      if (delta > ANGLE_HALF)
         delta -= ANGLE_RANGE;
      else if (delta < -ANGLE_HALF)
         delta += ANGLE_RANGE;
      if (delta > int'(threshold_now)) begin
         phase[axis] = phase[axis] + 2'd1;
         stepped = 1'b1;
      end else if (delta < -int'(threshold_now)) begin
         phase[axis] = phase[axis] - 2'd1;
         stepped = 1'b1;
      end
      if (stepped) begin
         anchor[axis]  = sample;
         threshold_now = thr_low;
         idle_count    = '0;
      end else if (idle_count > idle_limit && threshold_now < thr_high) begin
         threshold_now = threshold_now + 1'b1;
      end
      // Gray sequence: A = 1,1,0,0 and B = 0,1,1,0 over phases 0..3
      quad.phase_a = ~phase[axis][1];
      quad.phase_b = phase[axis][1] ^ phase[axis][0];
      pending_quadrature.push_back(quad);
   endfunction

   // Send one request, with random gaps ahead of it
   task automatic send_sample(input logic [AXW-1:0] axis,
                              input logic [SW-1:0] sample,
                              input logic frame);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, sample, axis};
      req_tuser  <= frame;
      do @(posedge clock); while (!req_tready);
      emulate_encoder(axis, sample, frame);
   endtask

   // Stop requests and let every expected result come out
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (pending_quadrature.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input a2q_pkg::reg_index_type index,
                                 input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         a2q_pkg::REG_AXIS_MASK:      axis_enable = value[MW-1:0];
         a2q_pkg::REG_THRESHOLD_HIGH: thr_high    = value[TW-1:0];
         a2q_pkg::REG_THRESHOLD_LOW:  thr_low     = value[TW-1:0];
         a2q_pkg::REG_IDLE_FRAMES:    idle_limit  = value[IW-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [MW-1:0] mask,
                                 input logic [TW-1:0] high,
                                 input logic [TW-1:0] low,
                                 input logic [IW-1:0] idle);
      wait_drained();
      write_register(a2q_pkg::REG_AXIS_MASK, 32'(mask));
      write_register(a2q_pkg::REG_THRESHOLD_HIGH, 32'(high));
      write_register(a2q_pkg::REG_THRESHOLD_LOW, 32'(low));
      write_register(a2q_pkg::REG_IDLE_FRAMES, 32'(idle));
   endtask

   // Sample near the axis anchor about half of the time, so both steps and holds happen
   function automatic logic [SW-1:0] pick_sample(input logic [AXW-1:0] axis);
      int offset;
      case ($urandom_range(9))
         0, 1, 2:    return SW'($urandom_range(ANGLE_RANGE - 1));
         3, 4, 5, 6: offset = int'(threshold_now) + int'($urandom_range(6)) - 3;
         7:          offset = $urandom_range(20);
         8:          offset = ANGLE_HALF - 1 + int'($urandom_range(2));
         default:    return $urandom_range(1) ? '1 : '0;
      endcase
      if ($urandom_range(1))
         offset = -offset;
      return SW'(int'(anchor[axis]) + offset);
   endfunction

   task automatic random_segment(input int count);
      logic [MW-1:0]  mask;
      logic [TW-1:0]  high;
      logic [TW-1:0]  low;
      logic [IW-1:0]  idle;
      logic [AXW-1:0] axis;
      mask = ($urandom_range(3) == 0) ? '1 : MW'($urandom_range(1, 255));
      case ($urandom_range(4))
         0:       high = '0;
         1:       high = '1;
         default: high = TW'($urandom_range(1200));
      endcase
      case ($urandom_range(4))
         0:       low = '0;
         1:       low = '1;
         default: low = TW'($urandom_range(600));
      endcase
      case ($urandom_range(4))
         0:       idle = '0;
         1:       idle = '1;
         default: idle = IW'($urandom_range(30));
      endcase
      apply_settings(mask, high, low, idle);
      repeat (count) begin
         axis = AXW'($urandom_range(AXES - 1));
         // mostly enabled axes, some traffic to disabled ones
         if ($urandom_range(3) != 0)
            while (!axis_enable[axis]) axis = AXW'($urandom_range(AXES - 1));
         send_sample(axis, pick_sample(axis), $urandom_range(2) == 0);
      end
   endtask

   // Mask is zero after reset: no axis produces results
   task automatic test_disabled_axes;
      send_sample(3'd0, 12'd4095, 1'b1);
      send_sample(3'd7, 12'd0, 1'b1);
      send_sample(3'd3, 12'hAAA, 1'b0);
   endtask

   // First samples prime an axis; a zero sample leaves it unprimed
   task automatic test_priming;
      wait_drained();
      write_register(a2q_pkg::REG_AXIS_MASK, 32'hFF);
      send_sample(3'd0, 12'd0, 1'b0);
      send_sample(3'd0, 12'd0, 1'b1);
      send_sample(3'd0, 12'd4095, 1'b1);
      send_sample(3'd7, 12'd2048, 1'b0);
      send_sample(3'd5, 12'd1, 1'b0);
      send_sample(3'd2, 12'h555, 1'b0);
   endtask

   // Steps both ways, threshold edges, half-turn deltas, phase wrap
   task automatic test_phase_steps;
      send_sample(3'd0, 12'd1000, 1'b0);
      send_sample(3'd0, 12'd1201, 1'b1);
      send_sample(3'd0, 12'd1000, 1'b0);
      send_sample(3'd0, 12'd1200, 1'b0);
      send_sample(3'd0, 12'd800, 1'b0);
      send_sample(3'd7, 12'd0, 1'b0);
      send_sample(3'd7, 12'd100, 1'b0);
      send_sample(3'd7, 12'd2148, 1'b0);
      send_sample(3'd5, 12'd2049, 1'b0);
      send_sample(3'd5, 12'd4095, 1'b1);
      send_sample(3'd0, 12'd1300, 1'b0);
      send_sample(3'd0, 12'd1600, 1'b0);
      send_sample(3'd0, 12'd1900, 1'b0);
   endtask

   // Threshold at or above the high limit holds; a step loads the low value
   task automatic test_threshold_limits;
      apply_settings('1, '0, '1, '0);
      send_sample(3'd0, 12'd1950, 1'b1);
      send_sample(3'd0, 12'd2101, 1'b1);
      send_sample(3'd0, 12'd4000, 1'b1);
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      repeat (4) random_segment(125);
   endtask

   // Frames on disabled axes run the idle counter past its limit, then the
   // threshold creeps up one per held sample
   task automatic test_idle_creep;
      apply_settings(8'h01, '1, '0, 16'd5);
      send_sample(3'd0, 12'd1234, 1'b0);
      repeat (12)
         send_sample(AXW'($urandom_range(1, AXES - 1)),
                     SW'($urandom_range(ANGLE_RANGE - 1)), 1'b1);
      repeat (30) send_sample(3'd0, anchor[0], 1'b0);
      repeat (6) send_sample(3'd0, pick_sample(3'd0), 1'b0);
   endtask

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each result with the oldest expected one
   always @(posedge clock) begin : check_results
      a2q_pkg::rsp_type got;
      a2q_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = a2q_pkg::rsp_type'(rsp_tdata[4:0]);
         if (pending_quadrature.size() == 0) begin
            $error("unexpected result: axis_slot %0d", got.axis_slot);
            error_count++;
         end else begin
            want = pending_quadrature.pop_front();
            if (got.axis_slot !== want.axis_slot) begin
               $error("axis_slot expected %0d actual %0d", want.axis_slot, got.axis_slot);
               error_count++;
            end
            if (got.phase_a !== want.phase_a) begin
               $error("phase_a expected %0b actual %0b", want.phase_a, got.phase_a);
               error_count++;
            end
            if (got.phase_b !== want.phase_b) begin
               $error("phase_b expected %0b actual %0b", want.phase_b, got.phase_b);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("angle_to_quadrature_encoder test failed");
            $finish;
         end
      end
   end

   initial begin
      for (int n = 0; n < AXES; n++) begin
         anchor[n] = '0;
         phase[n]  = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_disabled_axes();
      test_priming();
      test_phase_steps();
      test_threshold_limits();
      test_random_traffic(8, 77);
      test_random_traffic(77, 8);
      test_random_traffic(0, 0);
      test_idle_creep();
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("angle_to_quadrature_encoder test passed");
      else
         $display("angle_to_quadrature_encoder test failed");
      $finish;
   end

endmodule
